// File: design/ftr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftr_pkg
// Shared types and constants for the framed telegram receiver.
// ----------------------------------------------------------------------------
package ftr_pkg;

	localparam int DATA_CAPACITY_DEF = 64;
	localparam int QUEUE_DEPTH_DEF   = 2;

	// configuration register indexes
	localparam logic [1:0] CFG_PING = 2'd0;
	localparam logic [1:0] CFG_ACK  = 2'd1;
	localparam logic [1:0] CFG_NACK = 2'd2;
	localparam logic [1:0] CFG_GAP  = 2'd3;

	localparam logic [7:0]  PING_RST = 8'd5;
	localparam logic [7:0]  ACK_RST  = 8'd6;
	localparam logic [7:0]  NACK_RST = 8'd21;
	localparam logic [15:0] GAP_RST  = 16'd20;

	// frame status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_SUM_ERR = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	// classified input item passed from front to back
	typedef struct packed {
		logic       is_tick;
		logic       is_short;   // command matches ping, ack or nack
		logic [7:0] byte_val;
	} ftr_item_t;

endpackage
`default_nettype wire

// File: design/ftr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftr_front
// Input stage: takes stream transfers and classifies them into queue items.
// ----------------------------------------------------------------------------
module ftr_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [7:0]        s_axis_tdata,   // [7:0] byte_value
	input  wire logic              s_axis_tuser,   // [0] opcode
	input  wire logic [7:0]        ping_code,
	input  wire logic [7:0]        ack_code,
	input  wire logic [7:0]        nack_code,
	output logic                   push_valid,
	output ftr_pkg::ftr_item_t     push_item,
	input  wire logic              push_ready
);
	import ftr_pkg::*;

	logic      valid_s1;
	ftr_item_t item_s1;
	ftr_item_t item_d;
	logic      take;

	assign s_axis_tready = !valid_s1 || push_ready;
	assign take          = s_axis_tvalid && s_axis_tready;

	always_comb begin
		item_d.is_tick  = s_axis_tuser;
		item_d.byte_val = s_axis_tdata;
		item_d.is_short = (s_axis_tdata == ping_code) || (s_axis_tdata == ack_code) ||
			(s_axis_tdata == nack_code);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= item_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_item  = item_s1;

endmodule
`default_nettype wire

// File: design/ftr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftr_queue
// Small register FIFO between the classifier and the frame parser.
// ----------------------------------------------------------------------------
module ftr_queue #(
	parameter int DEPTH = ftr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push_valid,
	input  wire ftr_pkg::ftr_item_t push_item,
	output logic                   push_ready,
	output logic                   pop_valid,
	output ftr_pkg::ftr_item_t     pop_item,
	input  wire logic              pop_ready
);
	import ftr_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	ftr_item_t       mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue occupancy above depth");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) || (count_q == CW'(DEPTH)) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers disagree with occupancy");

endmodule
`default_nettype wire

// File: design/ftr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ftr_back
// Frame parser: walks command, length, data and checksum phases, tracks the
// inter-byte gap and drives the registered result stream.
// ----------------------------------------------------------------------------
module ftr_back #(
	parameter int DATA_CAPACITY = ftr_pkg::DATA_CAPACITY_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               pop_valid,
	input  wire ftr_pkg::ftr_item_t pop_item,
	output logic                    pop_ready,
	input  wire logic [15:0]        gap_timeout_ticks,
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	// [7:0] command, [15:8] frame_length, [23:16] data_byte, [31:24] byte_index,
	// [33:32] status, [41:34] computed_checksum, [49:42] received_checksum
	output logic [55:0]             m_axis_tdata,
	output logic                    m_axis_tlast     // result_kind
);
	import ftr_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_LEN,
		PH_DATA,
		PH_SUM
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [7:0]  command_q, command_d;
	logic [7:0]  length_q, length_d;
	logic [7:0]  rcv_cnt_q, rcv_cnt_d;
	logic [7:0]  kept_q, kept_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] gap_q, gap_d;
	logic [15:0] gap_inc;

	logic        out_valid_q;
	logic        last_q;
	logic [7:0]  o_command_q, o_length_q, o_data_q, o_index_q, o_comp_q, o_rcv_q;
	logic [1:0]  o_status_q;

	logic        has_res;
	logic        r_last;
	logic [7:0]  r_data, r_index, r_rcv;
	logic [1:0]  r_status;
	logic        pop;
	logic [7:0]  b;

	assign pop_ready = m_axis_tready || !out_valid_q;
	assign pop       = pop_valid && pop_ready;
	assign b         = pop_item.byte_val;
	assign gap_inc   = (gap_q != 16'hFFFF) ? gap_q + 16'd1 : gap_q;

	always_comb begin
		phase_d   = phase_q;
		command_d = command_q;
		length_d  = length_q;
		rcv_cnt_d = rcv_cnt_q;
		kept_d    = kept_q;
		sum_d     = sum_q;
		gap_d     = gap_q;
		has_res   = 1'b0;
		r_last    = 1'b1;
		r_data    = '0;
		r_index   = '0;
		r_status  = ST_OK;
		r_rcv     = '0;
		if (pop_item.is_tick) begin
			if (phase_q != PH_IDLE) begin
				gap_d = gap_inc;
				if (gap_inc >= gap_timeout_ticks) begin
					has_res  = 1'b1;
					r_status = ST_TIMEOUT;
					phase_d  = PH_IDLE;
					gap_d    = '0;
				end
			end
		end else begin
			gap_d = '0;
			case (phase_q)
				PH_IDLE: begin
					command_d = b;
					length_d  = '0;
					rcv_cnt_d = '0;
					kept_d    = '0;
					sum_d     = '0;
					if (pop_item.is_short) begin
						has_res = 1'b1;
					end else begin
						phase_d = PH_LEN;
					end
				end
				PH_LEN: begin
					length_d = b;
					phase_d  = (b == 8'd0) ? PH_SUM : PH_DATA;
				end
				PH_DATA: begin
					if (kept_q < 8'(DATA_CAPACITY)) begin
						kept_d = kept_q + 8'd1;
						sum_d  = sum_q + b;
					end
					rcv_cnt_d = rcv_cnt_q + 8'd1;
					if (rcv_cnt_d >= length_q) begin
						phase_d = PH_SUM;
					end
					has_res = 1'b1;
					r_last  = 1'b0;
					r_data  = b;
					r_index = rcv_cnt_q;
				end
				PH_SUM: begin
					has_res  = 1'b1;
					r_status = ((kept_q + sum_q) == b) ? ST_OK : ST_SUM_ERR;
					r_rcv    = b;
					phase_d  = PH_IDLE;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			command_q   <= '0;
			length_q    <= '0;
			rcv_cnt_q   <= '0;
			kept_q      <= '0;
			sum_q       <= '0;
			gap_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q   <= phase_d;
				command_q <= command_d;
				length_q  <= length_d;
				rcv_cnt_q <= rcv_cnt_d;
				kept_q    <= kept_d;
				sum_q     <= sum_d;
				gap_q     <= gap_d;
			end
			if (pop_ready) begin
				out_valid_q <= pop && has_res;
			end
		end
	end

	// result payload, loaded with the state it reports
	always_ff @(posedge clk) begin
		if (pop && has_res) begin
			last_q      <= r_last;
			o_command_q <= command_d;
			o_length_q  <= length_d;
			o_data_q    <= r_data;
			o_index_q   <= r_index;
			o_status_q  <= r_status;
			o_comp_q    <= kept_d + sum_d;
			o_rcv_q     <= r_rcv;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {6'd0, o_rcv_q, o_comp_q, o_status_q, o_index_q, o_data_q,
		o_length_q, o_command_q};

	a_idx_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_q |-> (o_index_q < o_length_q))
		else $error("data transfer index outside declared length");

	a_kept_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(kept_q <= 8'(DATA_CAPACITY)) && (kept_q <= rcv_cnt_q))
		else $error("kept count beyond capacity or received count");

	a_idle_gap: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> gap_q == '0)
		else $error("gap counter running while idle");

endmodule
`default_nettype wire

// File: design/framed_telegram_receiver.sv
// A result passes the classify register, a queue entry, then the parser's output
// register, and is held back further under back-pressure.
// Throughput: one input transfer per cycle while the queue has room; the parser retires
// one queued item per cycle whenever its output register is empty or being drained.
// Reset: asynchronous, clears queue, parser state and output valid, and
// loads the configuration registers with their default codes and timeout.
`default_nettype none
// ----------------------------------------------------------------------------
// framed_telegram_receiver
// Length-prefixed frame parser with additive checksum and gap timeout.
// ----------------------------------------------------------------------------
module framed_telegram_receiver #(
	parameter int DATA_CAPACITY = ftr_pkg::DATA_CAPACITY_DEF,
	parameter int QUEUE_DEPTH   = ftr_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] byte_value
	input  wire logic        s_axis_tuser,   // [0] opcode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] command, [15:8] frame_length, [23:16] data_byte, [31:24] byte_index,
	// [33:32] status, [41:34] computed_checksum, [49:42] received_checksum
	output logic [55:0]      m_axis_tdata,
	output logic             m_axis_tlast,   // result_kind
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_wdata
);
	import ftr_pkg::*;

	logic [7:0]  ping_q, ack_q, nack_q;
	logic [15:0] gap_to_q;

	logic        push_valid, push_ready, pop_valid, pop_ready;
	ftr_item_t   push_item, pop_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ping_q   <= PING_RST;
			ack_q    <= ACK_RST;
			nack_q   <= NACK_RST;
			gap_to_q <= GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PING: ping_q   <= cfg_wdata[7:0];
				CFG_ACK:  ack_q    <= cfg_wdata[7:0];
				CFG_NACK: nack_q   <= cfg_wdata[7:0];
				CFG_GAP:  gap_to_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ftr_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.ping_code     (ping_q),
		.ack_code      (ack_q),
		.nack_code     (nack_q),
		.push_valid    (push_valid),
		.push_item     (push_item),
		.push_ready    (push_ready)
	);

	ftr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_item  (push_item),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_item   (pop_item),
		.pop_ready  (pop_ready)
	);

	ftr_back #(
		.DATA_CAPACITY (DATA_CAPACITY)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.pop_valid         (pop_valid),
		.pop_item          (pop_item),
		.pop_ready         (pop_ready),
		.gap_timeout_ticks (gap_to_q),
		.m_axis_tvalid     (m_axis_tvalid),
		.m_axis_tready     (m_axis_tready),
		.m_axis_tdata      (m_axis_tdata),
		.m_axis_tlast      (m_axis_tlast)
	);

endmodule
`default_nettype wire

// File: tb/tb_framed_telegram_receiver.sv
// ----------------------------------------------------------------------------
// tb_framed_telegram_receiver
// Self-checking bench for the framed telegram receiver: a cycle-free parser
// model predicts data and frame-finished results for every accepted byte or
// tick; a checker compares each output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_framed_telegram_receiver;
	import ftr_pkg::*;

	localparam int          CAPACITY     = DATA_CAPACITY_DEF;
	localparam int          CYCLE_LIMIT  = 3_000_000;
	localparam int          SETTLE       = 10;
	localparam int          RAND_PHASES  = 4;
	localparam int          PHASE_ITEMS  = 360;
	localparam logic        OP_BYTE      = 1'b0;
	localparam logic        OP_TICK      = 1'b1;
	localparam logic        KIND_DATA    = 1'b0;
	localparam logic        KIND_DONE    = 1'b1;

	typedef enum logic [1:0] {AWAIT_CMD, AWAIT_LEN, AWAIT_DATA, AWAIT_SUM} parse_phase_t;

	typedef struct {
		logic       kind;
		logic [7:0] command;
		logic [7:0] frame_length;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		logic [1:0] status;
		logic [7:0] computed;
		logic [7:0] received;
	} frame_result_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] byte_value
	logic        s_axis_tuser;   // [0] opcode
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// [7:0] command, [15:8] frame_length, [23:16] data_byte, [31:24] byte_index,
	// [33:32] status, [41:34] computed_checksum, [49:42] received_checksum
	logic [55:0] m_axis_tdata;
	logic        m_axis_tlast;   // result_kind
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_wdata;

	// parser model state and its copy of the registers
	parse_phase_t parse_phase;
	logic [7:0]   cur_cmd;
	logic [7:0]   cur_len;
	logic [7:0]   rx_count;
	logic [7:0]   kept_count;
	logic [7:0]   kept_sum;
	logic [15:0]  gap_count;
	logic [7:0]   ping_code;
	logic [7:0]   ack_code;
	logic [7:0]   nack_code;
	logic [15:0]  gap_limit;

	frame_result_t expected_results[$];

	bit idle_on;
	int fail_count;
	int cycle_count;
	int items_sent;
	int data_seen;
	int frames_ok;
	int frames_bad_sum;
	int frames_timed_out;

	framed_telegram_receiver dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [7:0] frame_sum();
		return kept_count + kept_sum;
	endfunction

	function automatic bit is_short_code(logic [7:0] c);
		return c == ping_code || c == ack_code || c == nack_code;
	endfunction

	function automatic logic [7:0] pick_long_cmd();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (is_short_code(c));
		return c;
	endfunction

	function automatic void post_result(logic kind, logic [7:0] data, logic [7:0] idx,
			logic [1:0] st, logic [7:0] rx);
		frame_result_t r;
		r.kind         = kind;
		r.command      = cur_cmd;
		r.frame_length = cur_len;
		r.data_byte    = data;
		r.byte_index   = idx;
		r.status       = st;
		r.computed     = frame_sum();
		r.received     = rx;
		expected_results.push_back(r);
	endfunction

	function automatic void advance_parser(logic op, logic [7:0] b);
		logic [7:0] idx;
		if (op == OP_TICK) begin
			if (parse_phase == AWAIT_CMD)
				return;
			if (gap_count != 16'hFFFF)
				gap_count++;
			if (gap_count >= gap_limit) begin
				post_result(KIND_DONE, 8'd0, 8'd0, ST_TIMEOUT, 8'd0);
				parse_phase = AWAIT_CMD;
				gap_count   = 16'd0;
			end
			return;
		end
		gap_count = 16'd0;
		case (parse_phase)
			AWAIT_CMD: begin
				cur_cmd    = b;
				cur_len    = 8'd0;
				rx_count   = 8'd0;
				kept_count = 8'd0;
				kept_sum   = 8'd0;
				if (is_short_code(b))
					post_result(KIND_DONE, 8'd0, 8'd0, ST_OK, 8'd0);
				else
					parse_phase = AWAIT_LEN;
			end
			AWAIT_LEN: begin
				cur_len     = b;
				parse_phase = (b == 8'd0) ? AWAIT_SUM : AWAIT_DATA;
			end
			AWAIT_DATA: begin
				idx = rx_count;
				// bytes past capacity are consumed but not summed
				if (kept_count < CAPACITY) begin
					kept_count++;
					kept_sum += b;
				end
				rx_count++;
				if (rx_count >= cur_len)
					parse_phase = AWAIT_SUM;
				post_result(KIND_DATA, b, idx, ST_OK, 8'd0);
			end
			default: begin
				post_result(KIND_DONE, 8'd0, 8'd0, (frame_sum() == b) ? ST_OK : ST_SUM_ERR, b);
				parse_phase = AWAIT_CMD;
			end
		endcase
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_item(logic op, logic [7:0] b);
		if (idle_on && $urandom_range(99) < 34) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= b;
		do @(posedge clk); while (!s_axis_tready);
		advance_parser(op, b);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			CFG_PING: ping_code = value[7:0];
			CFG_ACK:  ack_code  = value[7:0];
			CFG_NACK: nack_code = value[7:0];
			default:  gap_limit = value;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic write_all_regs(logic [7:0] p, logic [7:0] a, logic [7:0] n,
			logic [15:0] g);
		write_reg(CFG_PING, {8'd0, p});
		write_reg(CFG_ACK, {8'd0, a});
		write_reg(CFG_NACK, {8'd0, n});
		write_reg(CFG_GAP, g);
	endtask

	// finish any open frame, then hold off until the pipeline is empty
	task automatic wait_results_drained();
		while (parse_phase != AWAIT_CMD)
			send_item(OP_BYTE, 8'($urandom_range(255)));
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// sometimes a run of ticks between bytes, occasionally long enough to time out
	task automatic tick_gap();
		int n;
		if ($urandom_range(99) >= 12)
			return;
		if (gap_limit > 1 && $urandom_range(3) != 0)
			n = $urandom_range(1, (gap_limit - 1 < 40) ? gap_limit - 1 : 40);
		else if (gap_limit <= 60)
			n = int'(gap_limit);
		else
			return;
		repeat (n) send_item(OP_TICK, 8'($urandom_range(255)));
	endtask

	task automatic send_random_frame();
		int pick;
		int len;
		int k;
		pick = $urandom_range(99);
		if (pick < 8) begin
			repeat ($urandom_range(1, 4))
				send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
			return;
		end
		if (pick < 20) begin
			case ($urandom_range(2))
				0: send_item(OP_BYTE, ping_code);
				1: send_item(OP_BYTE, ack_code);
				default: send_item(OP_BYTE, nack_code);
			endcase
			return;
		end
		send_item(OP_BYTE, pick_long_cmd());
		tick_gap();
		if (parse_phase == AWAIT_CMD)
			return;
		pick = $urandom_range(99);
		if (pick < 70)
			len = $urandom_range(0, 8);
		else if (pick < 88)
			len = $urandom_range(9, 70);
		else if (pick < 94)
			len = $urandom_range(71, 254);
		else
			len = 255;
		send_item(OP_BYTE, 8'(len));
		for (k = 0; k < len; k++) begin
			tick_gap();
			if (parse_phase == AWAIT_CMD)
				return;
			send_item(OP_BYTE, 8'($urandom_range(255)));
		end
		tick_gap();
		if (parse_phase == AWAIT_CMD)
			return;
		send_item(OP_BYTE, ($urandom_range(3) != 0) ? frame_sum() : 8'($urandom_range(255)));
	endtask

	task automatic test_short_frames();
		send_item(OP_TICK, 8'hA5);
		send_item(OP_BYTE, PING_RST);
		send_item(OP_BYTE, ACK_RST);
		send_item(OP_BYTE, NACK_RST);
		wait_results_drained();
		write_reg(CFG_PING, 16'h0000);
		write_reg(CFG_ACK, 16'h00FF);
		write_reg(CFG_NACK, 16'h0080);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, 8'h80);
	endtask

	task automatic test_zero_length();
		send_item(OP_BYTE, 8'h5A);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'h33);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'hFF);
	endtask

	task automatic test_checksum();
		send_item(OP_BYTE, 8'h01);
		send_item(OP_BYTE, 8'h02);
		send_item(OP_BYTE, 8'hFF);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_BYTE, 8'h01);  // 2 + 0xFF wraps to 0x01
	endtask

	task automatic test_gap_timeout();
		wait_results_drained();
		write_reg(CFG_GAP, 16'd2);
		send_item(OP_BYTE, 8'h42);
		send_item(OP_TICK, 8'h00);
		send_item(OP_TICK, 8'hFF);
		send_item(OP_BYTE, 8'h42);
		send_item(OP_BYTE, 8'h01);
		send_item(OP_TICK, 8'h00);
		send_item(OP_TICK, 8'h00);
		wait_results_drained();
		write_reg(CFG_GAP, 16'd1);
		send_item(OP_BYTE, 8'h42);
		send_item(OP_BYTE, 8'h00);
		send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, 8'h42);
		send_item(OP_TICK, 8'h00);
	endtask

	task automatic test_random_traffic();
		int phase_no;
		int start;
		for (phase_no = 0; phase_no < RAND_PHASES; phase_no++) begin
			wait_results_drained();
			case (phase_no)
				0: write_all_regs(8'h00, 8'hFF, 8'($urandom_range(255)), 16'd1);
				1: write_all_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 16'($urandom_range(2, 8)));
				2: begin
					start = $urandom_range(255);
					write_all_regs(8'(start), 8'(start), 8'(start), 16'd20);
				end
				default: write_all_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 16'($urandom_range(9, 40)));
			endcase
			// one phase runs with no idling on either side
			idle_on = (phase_no != 2);
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS)
				send_random_frame();
		end
		idle_on = 1'b1;
	endtask

	// timeout above one byte wide: one tick short of it, then exactly at it
	task automatic test_long_gap();
		wait_results_drained();
		write_reg(CFG_GAP, 16'h0100);
		idle_on = 1'b0;
		send_item(OP_BYTE, pick_long_cmd());
		repeat (16'h00FF) send_item(OP_TICK, 8'h00);
		send_item(OP_BYTE, 8'h01);
		send_item(OP_BYTE, 8'hC3);
		repeat (16'h0100) send_item(OP_TICK, 8'h00);
		idle_on = 1'b1;
		wait_results_drained();
	endtask

	function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		frame_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with nothing expected");
				fail_count++;
			end else begin
				want = expected_results.pop_front();
				compare_field("result_kind", want.kind, m_axis_tlast);
				compare_field("command", want.command, m_axis_tdata[7:0]);
				compare_field("frame_length", want.frame_length, m_axis_tdata[15:8]);
				compare_field("data_byte", want.data_byte, m_axis_tdata[23:16]);
				compare_field("byte_index", want.byte_index, m_axis_tdata[31:24]);
				compare_field("status", want.status, m_axis_tdata[33:32]);
				compare_field("computed_checksum", want.computed, m_axis_tdata[41:34]);
				compare_field("received_checksum", want.received, m_axis_tdata[49:42]);
				if (want.kind == KIND_DATA)
					data_seen++;
				else if (want.status == ST_OK)
					frames_ok++;
				else if (want.status == ST_SUM_ERR)
					frames_bad_sum++;
				else
					frames_timed_out++;
			end
		end
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= idle_on ? ($urandom_range(99) >= 34) : 1'b1;
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 8'd0;
		s_axis_tuser  = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = 2'd0;
		cfg_wdata     = 16'd0;
		idle_on       = 1'b1;
		fail_count    = 0;
		items_sent    = 0;
		parse_phase   = AWAIT_CMD;
		cur_cmd       = 8'd0;
		cur_len       = 8'd0;
		rx_count      = 8'd0;
		kept_count    = 8'd0;
		kept_sum      = 8'd0;
		gap_count     = 16'd0;
		ping_code     = PING_RST;
		ack_code      = ACK_RST;
		nack_code     = NACK_RST;
		gap_limit     = GAP_RST;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_short_frames();
		test_zero_length();
		test_checksum();
		test_gap_timeout();
		test_random_traffic();
		test_long_gap();
		wait_results_drained();

		$display("%0d transfers in: %0d payload bytes, %0d good frames, %0d bad sums,",
			items_sent, data_seen, frames_ok, frames_bad_sum);
		$display("%0d gap timeouts, across several code and timeout settings",
			frames_timed_out);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
design/ftr_pkg.sv
design/ftr_front.sv
design/ftr_queue.sv
design/ftr_back.sv
design/framed_telegram_receiver.sv
tb/tb_framed_telegram_receiver.sv
